// File: rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants and helpers for the triangle plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int COORD_W           = 32;
   localparam int COLOR_W           = 24;
   localparam int NORMAL_W          = 18;
   localparam int PROD_W            = NORMAL_W + COORD_W;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 32;

   // quotient of one intersection: |e - s| * D(s) / den never exceeds |e - s|
   localparam int QUO_W          = COORD_W + 1;
   localparam int BITS_PER_STAGE = 3;
   localparam int DIV_STAGES     = (QUO_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   // partial products, numerator load, divide stages, final add
   localparam int LANE_LAT       = DIV_STAGES + 3;

   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_OFFSET = 3'd3;

   // signed width of the exact plane distance
   function automatic int dist_w(input int frac);
      int top;
      top = (31 + frac > 50) ? 31 + frac : 50;
      return top + 2;
   endfunction

endpackage

// File: rtl/tpc_lane.sv
// ----------------------------------------------------------------------------
// tpc_lane
// One coordinate of an intersection: s +/- floor(m * ds / den), pipelined.
// ----------------------------------------------------------------------------
module tpc_lane #(
   parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [tpc_pkg::COORD_W-1:0]     s_i,
   input  logic                                   neg_i,
   input  logic [tpc_pkg::QUO_W-1:0]              m_i,
   input  logic [tpc_pkg::dist_w(FRAC_BITS)-2:0]  ds_i,
   input  logic [tpc_pkg::dist_w(FRAC_BITS)-1:0]  den_i,
   output logic signed [tpc_pkg::COORD_W-1:0]     res_o
);

   localparam int DW  = tpc_pkg::dist_w(FRAC_BITS);
   localparam int AW  = DW - 1;
   localparam int QW  = tpc_pkg::QUO_W;
   localparam int PW  = QW + AW;
   localparam int RW  = DW + 1;
   localparam int NST = tpc_pkg::DIV_STAGES;
   localparam int BPS = tpc_pkg::BITS_PER_STAGE;
   localparam int CW  = tpc_pkg::COORD_W;

   logic [QW+31:0]      ppl_ff;
   logic [PW-33:0]      pph_ff;
   logic [DW-1:0]       denp_ff;
   logic signed [CW-1:0] sp_ff;
   logic                negp_ff;

   logic [RW-1:0]       rem_ff [NST+1];
   logic [QW-1:0]       low_ff [NST+1];
   logic [QW-1:0]       quo_ff [NST+1];
   logic [DW-1:0]       den_ff [NST+1];
   logic signed [CW-1:0] s_ff  [NST+1];
   logic                neg_ff [NST+1];

   logic [RW-1:0]       rem_in [NST];
   logic [QW-1:0]       low_in [NST];
   logic [QW-1:0]       quo_in [NST];

   logic [PW-1:0]       prod;
   logic signed [CW+1:0] val;
   logic signed [CW-1:0] res_ff;

   assign prod = PW'(ppl_ff) + (PW'(pph_ff) << 32);

   always_comb begin
      logic [RW-1:0] r;
      logic [QW-1:0] lo;
      logic [QW-1:0] q;
      for (int st = 0; st < NST; st++) begin
         r  = rem_ff[st];
         lo = low_ff[st];
         q  = quo_ff[st];
         for (int b = 0; b < BPS; b++) begin
            r  = {r[RW-2:0], lo[QW-1]};
            lo = lo << 1;
            if (r >= RW'(den_ff[st])) begin
               r = r - RW'(den_ff[st]);
               q = {q[QW-2:0], 1'b1};
            end else begin
               q = {q[QW-2:0], 1'b0};
            end
         end
         rem_in[st] = r;
         low_in[st] = lo;
         quo_in[st] = q;
      end
   end

   always_comb begin
      if (neg_ff[NST]) begin
         val = (CW+2)'(s_ff[NST]) - $signed({1'b0, quo_ff[NST]});
      end else begin
         val = (CW+2)'(s_ff[NST]) + $signed({1'b0, quo_ff[NST]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ppl_ff  <= (QW+32)'(m_i) * (QW+32)'(ds_i[31:0]);
         pph_ff  <= (PW-32)'(m_i) * (PW-32)'(ds_i[AW-1:32]);
         denp_ff <= den_i;
         sp_ff   <= s_i;
         negp_ff <= neg_i;

         rem_ff[0] <= RW'(prod[PW-1:QW]);
         low_ff[0] <= prod[QW-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= denp_ff;
         s_ff[0]   <= sp_ff;
         neg_ff[0] <= negp_ff;

         for (int st = 0; st < NST; st++) begin
            rem_ff[st+1] <= rem_in[st];
            low_ff[st+1] <= low_in[st];
            quo_ff[st+1] <= quo_in[st];
            den_ff[st+1] <= den_ff[st];
            s_ff[st+1]   <= s_ff[st];
            neg_ff[st+1] <= neg_ff[st];
         end

         // saturate to the coordinate range
         if (!val[CW+1] && (val[CW:CW-1] != 2'b00)) begin
            res_ff <= {1'b0, {(CW-1){1'b1}}};
         end else if (val[CW+1] && (val[CW:CW-1] != 2'b11)) begin
            res_ff <= {1'b1, {(CW-1){1'b0}}};
         end else begin
            res_ff <= val[CW-1:0];
         end
      end
   end

   assign res_o = res_ff;

endmodule

// File: rtl/triangle_plane_clipper.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper
// Clips one triangle against a configured plane, giving zero to two triangles.
// ----------------------------------------------------------------------------
// A word on req_ is one triangle: three xyz vertices in signed fixed point
// and a packed color. Each rsp_ word is one clipped triangle; rsp_last_of_run
// marks the final word made from a request. A triangle fully behind the plane
// yields no word. The csr_ port writes the plane normal and offset; write it
// only while no triangle is in flight. csr_ready is high outside reset.
// A request passes through distance products, distance sum, clip selection,
// six divide lanes (two intersections of three coordinates, 3 quotient bits
// per stage) and the output register. A request can enter every cycle while
// the pipe advances; a triangle cut into two words holds the output register
// and stalls the pipe until both are taken. Reset clears all valid bits,
// holds req_ready and csr_ready low and loads the default plane (normal +z,
// offset 0.1). While the receiver stalls with a triangle at the end, the whole
// pipeline holds in place and req_ready drops; nothing is lost or repeated.
module triangle_plane_clipper #(
   parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [tpc_pkg::COORD_W-1:0]    req_vertex0_x,
   input  logic signed [tpc_pkg::COORD_W-1:0]    req_vertex0_y,
   input  logic signed [tpc_pkg::COORD_W-1:0]    req_vertex0_z,
   input  logic signed [tpc_pkg::COORD_W-1:0]    req_vertex1_x,
   input  logic signed [tpc_pkg::COORD_W-1:0]    req_vertex1_y,
   input  logic signed [tpc_pkg::COORD_W-1:0]    req_vertex1_z,
   input  logic signed [tpc_pkg::COORD_W-1:0]    req_vertex2_x,
   input  logic signed [tpc_pkg::COORD_W-1:0]    req_vertex2_y,
   input  logic signed [tpc_pkg::COORD_W-1:0]    req_vertex2_z,
   input  logic [tpc_pkg::COLOR_W-1:0]           req_tri_color,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tpc_pkg::COORD_W-1:0]    rsp_out_vertex0_x,
   output logic signed [tpc_pkg::COORD_W-1:0]    rsp_out_vertex0_y,
   output logic signed [tpc_pkg::COORD_W-1:0]    rsp_out_vertex0_z,
   output logic signed [tpc_pkg::COORD_W-1:0]    rsp_out_vertex1_x,
   output logic signed [tpc_pkg::COORD_W-1:0]    rsp_out_vertex1_y,
   output logic signed [tpc_pkg::COORD_W-1:0]    rsp_out_vertex1_z,
   output logic signed [tpc_pkg::COORD_W-1:0]    rsp_out_vertex2_x,
   output logic signed [tpc_pkg::COORD_W-1:0]    rsp_out_vertex2_y,
   output logic signed [tpc_pkg::COORD_W-1:0]    rsp_out_vertex2_z,
   output logic [tpc_pkg::COLOR_W-1:0]           rsp_out_color,
   output logic                                  rsp_last_of_run,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tpc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tpc_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int DW  = tpc_pkg::dist_w(FRAC_BITS);
   localparam int AW  = DW - 1;
   localparam int CW  = tpc_pkg::COORD_W;
   localparam int NW  = tpc_pkg::NORMAL_W;
   localparam int PRW = tpc_pkg::PROD_W;
   localparam int QW  = tpc_pkg::QUO_W;
   localparam int LAT = tpc_pkg::LANE_LAT;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_ALL,
      MODE_ONE,
      MODE_TWO
   } mode_type;

   typedef struct packed {
      logic [2:0][2:0][CW-1:0]       vtx;
      logic [tpc_pkg::COLOR_W-1:0]   color;
      mode_type                      mode;
   } ctx_type;

   // plane registers
   logic signed [NW-1:0] nrm_ff [3];
   logic signed [CW-1:0] off_ff;

   // pipeline
   logic                  adv;
   logic                  va_ff;
   logic                  vb_ff;
   logic                  vl_ff [LAT+1];
   ctx_type               ctx_a_ff;
   ctx_type               ctx_b_ff;
   ctx_type               ctx_ff [LAT+1];
   ctx_type               ctx_in;
   logic signed [PRW-1:0] prod_a_ff [3][3];
   logic signed [DW-1:0]  d_b_ff [3];

   logic signed [CW-1:0]  vin [3][3];

   // stage C selection
   logic [2:0]            mask;
   logic [1:0]            si [2];
   logic [1:0]            ei [2];
   logic [1:0]            i0;
   logic [1:0]            i1;
   mode_type              mode;

   // lane inputs and results
   logic signed [CW-1:0]  li_s_ff   [2][3];
   logic                  li_neg_ff [2][3];
   logic [QW-1:0]         li_m_ff   [2][3];
   logic [AW-1:0]         li_ds_ff  [2];
   logic [DW-1:0]         li_den_ff [2];
   logic signed [CW-1:0]  xres      [2][3];

   // output register
   logic                  ob_valid_ff;
   logic                  ob_phase_ff;
   ctx_type               ob_ctx_ff;
   logic [CW-1:0]         ob_x_ff [2][3];
   logic                  ob_last;
   logic                  ob_free;
   logic                  ob_load;
   logic                  tail_drop;
   logic [CW-1:0]         ov [3][3];

   assign vin[0][0] = req_vertex0_x;
   assign vin[0][1] = req_vertex0_y;
   assign vin[0][2] = req_vertex0_z;
   assign vin[1][0] = req_vertex1_x;
   assign vin[1][1] = req_vertex1_y;
   assign vin[1][2] = req_vertex1_z;
   assign vin[2][0] = req_vertex2_x;
   assign vin[2][1] = req_vertex2_y;
   assign vin[2][2] = req_vertex2_z;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         nrm_ff[0] <= '0;
         nrm_ff[1] <= '0;
         nrm_ff[2] <= NW'(1 << FRAC_BITS);
         off_ff    <= CW'(6554);
      end else if (csr_valid) begin
         unique case (csr_index)
            tpc_pkg::REG_NORMAL_X:     nrm_ff[0] <= csr_data[NW-1:0];
            tpc_pkg::REG_NORMAL_Y:     nrm_ff[1] <= csr_data[NW-1:0];
            tpc_pkg::REG_NORMAL_Z:     nrm_ff[2] <= csr_data[NW-1:0];
            tpc_pkg::REG_PLANE_OFFSET: off_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // flow control: the whole pipe moves as one
   // ------------------------------------------------------------------
   assign ob_last   = (ob_ctx_ff.mode != MODE_TWO) || ob_phase_ff;
   assign ob_free   = !ob_valid_ff || (rsp_ready && ob_last);
   assign tail_drop = ctx_ff[LAT].mode == MODE_NONE;
   assign adv       = !vl_ff[LAT] || tail_drop || ob_free;
   assign ob_load   = adv && vl_ff[LAT] && !tail_drop;
   assign req_ready = adv && !reset;

   // ------------------------------------------------------------------
   // stage C: classify vertices and pick the clip edges
   // ------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mask[i] = !d_b_ff[i][DW-1] && (d_b_ff[i] != '0);
      end
      mode  = MODE_NONE;
      i0    = 2'd0;
      i1    = 2'd1;
      si[0] = 2'd0;
      ei[0] = 2'd0;
      si[1] = 2'd0;
      ei[1] = 2'd0;
      unique case (mask)
         3'b001: begin
            mode = MODE_ONE; i0 = 2'd0;
            si[0] = 2'd0; ei[0] = 2'd1; si[1] = 2'd0; ei[1] = 2'd2;
         end
         3'b010: begin
            mode = MODE_ONE; i0 = 2'd1;
            si[0] = 2'd1; ei[0] = 2'd0; si[1] = 2'd1; ei[1] = 2'd2;
         end
         3'b100: begin
            mode = MODE_ONE; i0 = 2'd2;
            si[0] = 2'd2; ei[0] = 2'd0; si[1] = 2'd2; ei[1] = 2'd1;
         end
         3'b011: begin
            mode = MODE_TWO; i0 = 2'd0; i1 = 2'd1;
            si[0] = 2'd0; ei[0] = 2'd2; si[1] = 2'd1; ei[1] = 2'd2;
         end
         3'b101: begin
            mode = MODE_TWO; i0 = 2'd0; i1 = 2'd2;
            si[0] = 2'd0; ei[0] = 2'd1; si[1] = 2'd2; ei[1] = 2'd1;
         end
         3'b110: begin
            mode = MODE_TWO; i0 = 2'd1; i1 = 2'd2;
            si[0] = 2'd1; ei[0] = 2'd0; si[1] = 2'd2; ei[1] = 2'd0;
         end
         3'b111: begin
            mode = MODE_ALL;
         end
         default: ;
      endcase
      ctx_in        = ctx_b_ff;
      ctx_in.mode   = mode;
      ctx_in.vtx[0] = ctx_b_ff.vtx[i0];
      ctx_in.vtx[1] = ctx_b_ff.vtx[i1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         for (int j = 0; j <= LAT; j++) begin
            vl_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         va_ff    <= req_valid;
         vb_ff    <= va_ff;
         vl_ff[0] <= vb_ff;
         for (int j = 0; j < LAT; j++) begin
            vl_ff[j+1] <= vl_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [CW:0] diff;
      if (adv) begin
         // stage A: distance products
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               ctx_a_ff.vtx[i][k] <= vin[i][k];
               prod_a_ff[i][k]    <= PRW'(nrm_ff[k]) * PRW'(vin[i][k]);
            end
         end
         ctx_a_ff.color <= req_tri_color;
         ctx_a_ff.mode  <= MODE_NONE;

         // stage B: distance sums
         ctx_b_ff <= ctx_a_ff;
         for (int i = 0; i < 3; i++) begin
            d_b_ff[i] <= DW'(prod_a_ff[i][0]) + DW'(prod_a_ff[i][1])
                       + DW'(prod_a_ff[i][2]) - (DW'(off_ff) <<< FRAC_BITS);
         end

         // stage C: edge selection into the lanes
         ctx_ff[0] <= ctx_in;
         for (int j = 0; j < 2; j++) begin
            li_ds_ff[j]  <= d_b_ff[si[j]][AW-1:0];
            li_den_ff[j] <= DW'(d_b_ff[si[j]] - d_b_ff[ei[j]]);
            for (int k = 0; k < 3; k++) begin
               diff = (CW+1)'($signed(ctx_b_ff.vtx[ei[j]][k]))
                    - (CW+1)'($signed(ctx_b_ff.vtx[si[j]][k]));
               li_s_ff[j][k]   <= ctx_b_ff.vtx[si[j]][k];
               li_neg_ff[j][k] <= diff[CW];
               li_m_ff[j][k]   <= diff[CW] ? QW'(-diff) : QW'(diff);
            end
         end

         // context rides along with the lanes
         for (int j = 0; j < LAT; j++) begin
            ctx_ff[j+1] <= ctx_ff[j];
         end
      end
   end

   for (genvar j = 0; j < 2; j++) begin : g_pair
      for (genvar k = 0; k < 3; k++) begin : g_coord
         tpc_lane #(
            .FRAC_BITS (FRAC_BITS)
         ) u_lane (
            .clock (clock),
            .en    (adv),
            .s_i   (li_s_ff[j][k]),
            .neg_i (li_neg_ff[j][k]),
            .m_i   (li_m_ff[j][k]),
            .ds_i  (li_ds_ff[j]),
            .den_i (li_den_ff[j]),
            .res_o (xres[j][k])
         );
      end
   end

   // ------------------------------------------------------------------
   // output register: one or two words per triangle
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ob_valid_ff <= 1'b0;
         ob_phase_ff <= 1'b0;
      end else if (ob_load) begin
         ob_valid_ff <= 1'b1;
         ob_phase_ff <= 1'b0;
      end else if (ob_valid_ff && rsp_ready) begin
         ob_valid_ff <= !ob_last;
         ob_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ob_load) begin
         ob_ctx_ff <= ctx_ff[LAT];
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 3; k++) begin
               ob_x_ff[j][k] <= xres[j][k];
            end
         end
      end
   end

   always_comb begin
      logic cut;
      cut = (ob_ctx_ff.mode == MODE_ONE) || ob_phase_ff;
      for (int k = 0; k < 3; k++) begin
         ov[0][k] = ob_phase_ff ? ob_ctx_ff.vtx[1][k] : ob_ctx_ff.vtx[0][k];
         ov[1][k] = cut ? ob_x_ff[0][k] : ob_ctx_ff.vtx[1][k];
         if (ob_ctx_ff.mode == MODE_ALL) begin
            ov[2][k] = ob_ctx_ff.vtx[2][k];
         end else begin
            ov[2][k] = cut ? ob_x_ff[1][k] : ob_x_ff[0][k];
         end
      end
   end

   assign rsp_valid         = ob_valid_ff;
   assign rsp_out_vertex0_x = ov[0][0];
   assign rsp_out_vertex0_y = ov[0][1];
   assign rsp_out_vertex0_z = ov[0][2];
   assign rsp_out_vertex1_x = ov[1][0];
   assign rsp_out_vertex1_y = ov[1][1];
   assign rsp_out_vertex1_z = ov[1][2];
   assign rsp_out_vertex2_x = ov[2][0];
   assign rsp_out_vertex2_y = ov[2][1];
   assign rsp_out_vertex2_z = ov[2][2];
   assign rsp_out_color     = ob_ctx_ff.color;
   assign rsp_last_of_run   = ob_last;

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper testbench
// Drives triangles against a series of plane settings, predicts the clipped
// triangles with an exact wide-arithmetic model and checks every rsp_ word.
// ----------------------------------------------------------------------------
module tb;

   typedef logic signed [31:0] coord_type;
   typedef coord_type vert_type [3];

   typedef struct {
      coord_type   c [9];
      logic [23:0] color;
   } tri_word_type;

   typedef struct {
      coord_type   c [9];
      logic [23:0] color;
      logic        last;
   } clip_word_type;

   int errors = 0;

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("MISMATCH %s got %0d want %0d at %0t", what, got, want, $time);
   endtask

   class clip_scoreboard;
      logic signed [17:0] nx = 0, ny = 0, nz = 18'sd65536;
      logic signed [31:0] offs = 32'sd6554;
      clip_word_type pending [$];

      function void set_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            tpc_pkg::REG_NORMAL_X:     nx = val[17:0];
            tpc_pkg::REG_NORMAL_Y:     ny = val[17:0];
            tpc_pkg::REG_NORMAL_Z:     nz = val[17:0];
            tpc_pkg::REG_PLANE_OFFSET: offs = val;
            default: ;
         endcase
      endfunction

      function logic signed [63:0] plane_dist(vert_type v);
         logic signed [63:0] s;
         s = 64'(nx) * 64'(v[0]) + 64'(ny) * 64'(v[1]) + 64'(nz) * 64'(v[2]);
         return s - (64'(offs) <<< tpc_pkg::FRAC_BITS_DEFAULT);
      endfunction

      function void cut_edge(vert_type s, logic signed [63:0] ds, vert_type e,
                             logic signed [63:0] de, output vert_type r);
         logic signed [64:0] d;
         logic [127:0] q;
         logic signed [65:0] v;
         for (int k = 0; k < 3; k++) begin
            d = 65'(e[k]) - 65'(s[k]);
            q = (128'(d < 0 ? -d : d) * 128'(ds)) / 128'(ds - de);
            v = d < 0 ? 66'(s[k]) - 66'(q) : 66'(s[k]) + 66'(q);
            if (v > 66'sd2147483647) v = 66'sd2147483647;
            if (v < -66'sd2147483648) v = -66'sd2147483648;
            r[k] = v[31:0];
         end
      endfunction

      function void push(vert_type a, vert_type b, vert_type c, logic [23:0] col,
                         logic last);
         clip_word_type w;
         for (int k = 0; k < 3; k++) begin
            w.c[k] = a[k]; w.c[3+k] = b[k]; w.c[6+k] = c[k];
         end
         w.color = col;
         w.last = last;
         pending.insert(pending.size(), w);
      endfunction

      function void note_triangle(tri_word_type t);
         vert_type v [3];
         vert_type x0, x1;
         logic signed [63:0] d [3];
         int ins [$], outs [$];
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) v[i][k] = t.c[i*3+k];
            d[i] = plane_dist(v[i]);
            if (d[i] > 0) ins.insert(ins.size(), i); else outs.insert(outs.size(), i);
         end
         if (ins.size() == 3) push(v[0], v[1], v[2], t.color, 1'b1);
         else if (ins.size() == 1) begin
            cut_edge(v[ins[0]], d[ins[0]], v[outs[0]], d[outs[0]], x0);
            cut_edge(v[ins[0]], d[ins[0]], v[outs[1]], d[outs[1]], x1);
            push(v[ins[0]], x0, x1, t.color, 1'b1);
         end else if (ins.size() == 2) begin
            cut_edge(v[ins[0]], d[ins[0]], v[outs[0]], d[outs[0]], x0);
            cut_edge(v[ins[1]], d[ins[1]], v[outs[0]], d[outs[0]], x1);
            push(v[ins[0]], v[ins[1]], x0, t.color, 1'b0);
            push(v[ins[1]], x0, x1, t.color, 1'b1);
         end
      endfunction

      task check_word(clip_word_type got);
         clip_word_type want;
         if (pending.size() == 0) begin
            report("unexpected word", 0, 0);
            return;
         end
         want = pending[0];
         pending.delete(0);
         for (int k = 0; k < 9; k++)
            if (got.c[k] !== want.c[k])
               report($sformatf("vertex%0d_%s", k / 3,
                                k % 3 == 0 ? "x" : k % 3 == 1 ? "y" : "z"),
                      got.c[k], want.c[k]);
         if (got.color !== want.color) report("color", got.color, want.color);
         if (got.last !== want.last) report("last_of_run", got.last, want.last);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0, rsp_last_of_run;
   coord_type rq [9];
   coord_type rs [9];
   logic [23:0] req_tri_color = 0, rsp_out_color;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   clip_scoreboard sb = new();
   longint idle_cycles = 0;
   bit hold_rsp = 0;

   initial for (int k = 0; k < 9; k++) rq[k] = 0;

   always #2 clock = ~clock;

   triangle_plane_clipper i_dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_vertex0_x(rq[0]), .req_vertex0_y(rq[1]), .req_vertex0_z(rq[2]),
      .req_vertex1_x(rq[3]), .req_vertex1_y(rq[4]), .req_vertex1_z(rq[5]),
      .req_vertex2_x(rq[6]), .req_vertex2_y(rq[7]), .req_vertex2_z(rq[8]),
      .req_tri_color, .rsp_valid, .rsp_ready,
      .rsp_out_vertex0_x(rs[0]), .rsp_out_vertex0_y(rs[1]), .rsp_out_vertex0_z(rs[2]),
      .rsp_out_vertex1_x(rs[3]), .rsp_out_vertex1_y(rs[4]), .rsp_out_vertex1_z(rs[5]),
      .rsp_out_vertex2_x(rs[6]), .rsp_out_vertex2_y(rs[7]), .rsp_out_vertex2_z(rs[8]),
      .rsp_out_color, .rsp_last_of_run, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   // check words and track progress at the rising edge
   always @(posedge clock) begin
      clip_word_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            for (int k = 0; k < 9; k++) w.c[k] = rs[k];
            w.color = rsp_out_color;
            w.last = rsp_last_of_run;
            sb.check_word(w);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles > 5000) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // receiver stall pattern, plus a forced hold-off
   always @(negedge clock) begin
      int p;
      p = $urandom_range(0, 99);
      if (hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= (p < 70) || (($time / 400) % 3 == 0);
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (tpc_pkg::LANE_LAT + 10) @(negedge clock);
   endtask

   task automatic send_tri(input tri_word_type t);
      for (int k = 0; k < 9; k++) rq[k] <= t.c[k];
      req_tri_color <= t.color;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_triangle(t);
      @(negedge clock);
   endtask

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
         2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   function automatic tri_word_type rand_tri();
      tri_word_type t;
      int m;
      m = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++)
         t.c[k] = rand_coord(m < 2 ? 0 : m < 8 ? 1 : m == 8 ? $urandom_range(0, 3) : 3);
      t.color = 24'($urandom());
      return t;
   endfunction

   task automatic random_burst(input int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         int len;
         len = $urandom_range(1, 12);
         for (int j = 0; j < len && sent < n; j++, sent++) send_tri(rand_tri());
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   function automatic tri_word_type mk(coord_type z0, coord_type z1, coord_type z2);
      tri_word_type t;
      t = rand_tri();
      t.c[2] = z0; t.c[5] = z1; t.c[8] = z2;
      return t;
   endfunction

   initial begin
      tri_word_type t;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default plane z > 0.1: every inside count and extreme values
      send_tri(mk(1 << 16, 2 << 16, 3 << 16));
      send_tri(mk(-(1 << 16), 2 << 16, -(3 << 16)));
      send_tri(mk(1 << 16, -(2 << 16), 3 << 16));
      send_tri(mk(-5, -7, 6554));
      send_tri(mk(6555, -1, 6554));
      send_tri(mk(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
      for (int k = 0; k < 9; k++) t.c[k] = k[0] ? 32'sh7fffffff : 32'sh80000000;
      t.color = 24'hffffff;
      send_tri(t);
      for (int k = 0; k < 9; k++) t.c[k] = 0;
      t.color = 0;
      send_tri(t);
      req_valid <= 1'b0;
      drain();

      // zero normal: whole or nothing, then negative offset
      write_reg(tpc_pkg::REG_NORMAL_Z, 0);
      send_tri(rand_tri());
      req_valid <= 1'b0;
      drain();
      write_reg(tpc_pkg::REG_PLANE_OFFSET, 32'hffff0000);
      send_tri(rand_tri());
      req_valid <= 1'b0;
      drain();

      // a long receiver hold-off fills the pipeline
      fork
         begin hold_rsp = 1; repeat (300) @(negedge clock); hold_rsp = 0; end
         random_burst(40);
      join
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(tpc_pkg::REG_NORMAL_X, 32'h10000);
                      write_reg(tpc_pkg::REG_NORMAL_Y, 0);
                      write_reg(tpc_pkg::REG_NORMAL_Z, 0);
                      write_reg(tpc_pkg::REG_PLANE_OFFSET, 0); end
            1: begin write_reg(tpc_pkg::REG_NORMAL_X, 32'h30000);
                      write_reg(tpc_pkg::REG_NORMAL_Y, 32'h10000);
                      write_reg(tpc_pkg::REG_NORMAL_Z, 32'h20000);
                      write_reg(tpc_pkg::REG_PLANE_OFFSET, 32'h80000000); end
            2: begin write_reg(tpc_pkg::REG_NORMAL_X, 32'h0b505);
                      write_reg(tpc_pkg::REG_NORMAL_Y, 32'h34afb);
                      write_reg(tpc_pkg::REG_NORMAL_Z, 0);
                      write_reg(tpc_pkg::REG_PLANE_OFFSET, 32'h7fffffff); end
            3: begin write_reg(tpc_pkg::REG_NORMAL_X, 32'h1ffff);
                      write_reg(tpc_pkg::REG_NORMAL_Y, 32'h20000);
                      write_reg(tpc_pkg::REG_NORMAL_Z, 32'h3ffff);
                      write_reg(tpc_pkg::REG_PLANE_OFFSET, 32'h100); end
            4: begin write_reg(3'd7, 32'h12345); write_reg(3'd5, 32'hffffffff); end
            default: for (int r = 0; r < 3; r++) begin
                        write_reg(r[2:0], 32'($signed($urandom_range(0, 131072)) - 65536));
                     end
         endcase
         random_burst(75);
         drain();
      end

      drain();
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
